// ===== rtl/iss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iss_pkg: shared definitions of the insertion sorter
// widths, defaults and the control bundle handed to every sorting cell
// ----------------------------------------------------------------------------
package iss_pkg;

	// default geometry
	localparam int DEPTH_DEF      = 16;
	localparam int VALUE_BITS_DEF = 32;

	// running shift total
	localparam int              SHIFT_BITS = 11;
	localparam logic [SHIFT_BITS-1:0] SHIFT_MAX = {SHIFT_BITS{1'b1}};

	// per-cell control from the top level
	typedef struct packed {
		logic insert;   // a word is being inserted this cycle
		logic drain;    // the row shifts down by one place
		logic valid;    // this cell holds a stored value
		logic at_fill;  // this cell is the first free place
	} cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/iss_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iss_in_if: input channel of the insertion sorter
// one word carries a value to sort and its end-of-set mark
// ----------------------------------------------------------------------------
interface iss_in_if #(
	parameter int VALUE_BITS = iss_pkg::VALUE_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;
	logic                         last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/iss_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iss_out_if: result channel of the insertion sorter
// one word carries a sorted value with run status
// ----------------------------------------------------------------------------
interface iss_out_if #(
	parameter int VALUE_BITS = iss_pkg::VALUE_BITS_DEF
);
	logic                            valid;
	logic                            ready;
	logic signed [VALUE_BITS-1:0]    sorted_value;
	logic                            end_of_run;
	logic [iss_pkg::SHIFT_BITS-1:0]  shift_count;
	logic                            overflow;

	modport source (output valid, output sorted_value, output end_of_run,
		output shift_count, output overflow, input ready);
	modport sink   (input valid, input sorted_value, input end_of_run,
		input shift_count, input overflow, output ready);
endinterface
`default_nettype wire

// ===== rtl/iss_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iss_cell: one place of the sorted row
// compares the incoming value with its own, shifts up on insert, down on drain
// ----------------------------------------------------------------------------
module iss_cell #(
	parameter int VALUE_BITS = iss_pkg::VALUE_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire iss_pkg::cell_ctl_t           ctl,
	input  wire logic signed [VALUE_BITS-1:0] new_val,
	input  wire logic signed [VALUE_BITS-1:0] left_val,
	input  wire logic                         left_gt,
	input  wire logic signed [VALUE_BITS-1:0] right_val,
	output logic signed [VALUE_BITS-1:0]      value,
	output logic                              gt,
	output logic                              take_new
);

	logic signed [VALUE_BITS-1:0] value_q;
	logic                         wr_en;

	// strictly greater stored values move up, equal ones stay below
	assign gt       = ctl.valid && (value_q > new_val);
	assign wr_en    = ctl.insert && (gt || ctl.at_fill);
	assign take_new = wr_en && !left_gt;
	assign value    = value_q;

	// insert takes the left neighbor or the new value, drain takes the right
	always_ff @(posedge clk) begin
		if (wr_en) begin
			value_q <= left_gt ? left_val : new_val;
		end else if (ctl.drain) begin
			value_q <= right_val;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/insertion_sorter_with_shift_count.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// insertion_sorter_with_shift_count: streaming insertion sorter
// row of compare-and-shift cells with a running shift (inversion) count
// ----------------------------------------------------------------------------
//  channel  dir  words                       payload
//  din      in   one per value               value, last
//  dout     out  fill count per set, on last sorted_value, end_of_run,
//                                            shift_count, overflow
//
//  din takes one word every cycle while collecting; all cells compare and shift in parallel.
//  after a word marked last: a settle state for the shift total, then one
//  result per cycle from cell 0 while dout.ready is high (row shifts down).
//  din stays blocked from the last word until the final result is taken.
//  reset clears fill count, shift total, overflow flag and state; cells are
//  not cleared, only places below the fill count are read.
// ----------------------------------------------------------------------------
module insertion_sorter_with_shift_count #(
	parameter int DEPTH      = iss_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = iss_pkg::VALUE_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	iss_in_if.sink     din,
	iss_out_if.source  dout
);

	localparam int FW = $clog2(DEPTH + 1);
	localparam int PW = $clog2(DEPTH);
	localparam int SB = iss_pkg::SHIFT_BITS;

	typedef enum logic [2:0] {
		ST_COLLECT = 3'b001,
		ST_SETTLE  = 3'b010,
		ST_DRAIN   = 3'b100
	} state_t;

	state_t              state_q;
	logic [FW-1:0]       fill_q;
	logic [SB-1:0]       total_q;
	logic                dropped_q;
	logic [FW-1:0]       delta_s1;

	logic                in_acc;
	logic                out_acc;
	logic                insert_en;
	logic                drain_en;
	logic [PW-1:0]       ins_pos;
	logic [FW-1:0]       shifts;
	logic [SB:0]         sum;

	logic signed [VALUE_BITS-1:0] cell_val [DEPTH];
	logic [DEPTH-1:0]             cell_gt;
	logic [DEPTH-1:0]             cell_new;

	// handshakes
	assign din.ready = (state_q == ST_COLLECT);
	assign in_acc    = din.valid && din.ready;
	assign out_acc   = dout.valid && dout.ready;
	assign insert_en = in_acc && (fill_q < FW'(DEPTH));
	assign drain_en  = out_acc;

	// row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		iss_pkg::cell_ctl_t           ctl;
		logic signed [VALUE_BITS-1:0] left_v;
		logic signed [VALUE_BITS-1:0] right_v;
		logic                         left_g;

		assign ctl.insert  = insert_en;
		assign ctl.drain   = drain_en;
		assign ctl.valid   = (FW'(i) < fill_q);
		assign ctl.at_fill = (FW'(i) == fill_q);

		if (i == 0) begin : g_first
			assign left_v = '0;
			assign left_g = 1'b0;
		end else begin : g_mid
			assign left_v = cell_val[i-1];
			assign left_g = cell_gt[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign right_v = '0;
		end else begin : g_inner
			assign right_v = cell_val[i+1];
		end

		iss_cell #(
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.new_val   (din.value),
			.left_val  (left_v),
			.left_gt   (left_g),
			.right_val (right_v),
			.value     (cell_val[i]),
			.gt        (cell_gt[i]),
			.take_new  (cell_new[i])
		);
	end

	// place of the new word, encoded from the one-hot take flags
	always_comb begin
		ins_pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			ins_pos = ins_pos | (cell_new[i] ? PW'(i) : '0);
		end
	end

	// words moved up equals fill minus the insert place
	assign shifts = fill_q - FW'(ins_pos);

	// saturating accumulate of the previous cycle's shifts
	assign sum = {1'b0, total_q} + (SB+1)'(delta_s1);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_COLLECT;
			fill_q    <= '0;
			total_q   <= '0;
			dropped_q <= 1'b0;
			delta_s1  <= '0;
		end else begin
			delta_s1 <= insert_en ? shifts : '0;
			// total clears with the final result of a set
			if ((state_q == ST_DRAIN) && out_acc && (fill_q == FW'(1))) begin
				total_q <= '0;
			end else begin
				total_q <= (sum > (SB+1)'(iss_pkg::SHIFT_MAX)) ? iss_pkg::SHIFT_MAX
					: sum[SB-1:0];
			end
			case (state_q)
				ST_COLLECT: begin
					if (insert_en) begin
						fill_q <= fill_q + FW'(1);
					end else if (in_acc) begin
						dropped_q <= 1'b1;
					end
					if (in_acc && din.last) begin
						state_q <= ST_SETTLE;
					end
				end
				ST_SETTLE: begin
					state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (out_acc) begin
						fill_q <= fill_q - FW'(1);
						if (fill_q == FW'(1)) begin
							state_q   <= ST_COLLECT;
							dropped_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

	// result word from the bottom cell
	assign dout.valid        = (state_q == ST_DRAIN);
	assign dout.sorted_value = cell_val[0];
	assign dout.end_of_run   = (fill_q == FW'(1));
	assign dout.shift_count  = total_q;
	assign dout.overflow     = dropped_q;

`ifndef SYNTHESIS
	// a draining row is never empty
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> (fill_q != '0))
		else $error("drain with empty row");

	// the new word lands in at most one cell
	a_one_place: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_new))
		else $error("new word taken by several cells");

	// an insert always lands somewhere
	a_insert_lands: assert property (@(posedge clk) disable iff (!arst_n)
		insert_en |-> $onehot(cell_new))
		else $error("insert found no place");

	// after the last word the settle state follows, with both sides closed
	a_settle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && din.last) |=> (!din.ready && !dout.valid))
		else $error("no settle cycle after last word");
`endif

endmodule
`default_nettype wire
